### design/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Types and constants shared by the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEADER    = 3'd1,
    PH_ADDRESS   = 3'd2,
    PH_COMMAND   = 3'd3,
    PH_UNPLUGGED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_KEY    = 2'd1,
    EV_UNPLUG = 2'd2
  } event_t;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_EDGE = 1'b1
  } opcode_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_LEADER_MIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_MAX    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ONE_MIN       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_MAX       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_UNPLUG_DETECT = 3'd5;

  localparam logic [15:0] LEADER_MIN_RST   = 16'd100;
  localparam logic [15:0] LEADER_MAX_RST   = 16'd150;
  localparam logic [15:0] ONE_MIN_RST      = 16'd18;
  localparam logic [15:0] ONE_MAX_RST      = 16'd25;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd250;

  localparam logic [15:0] TICK_SAT = 16'hFFFF;
  localparam logic [7:0]  CMD_CHECK = 8'hFF;
  localparam logic [3:0]  BIT_TOP = 4'd15;

  typedef struct packed {
    logic [15:0] leader_min;
    logic [15:0] leader_max;
    logic [15:0] one_min;
    logic [15:0] one_max;
    logic [15:0] idle_timeout;
    logic        unplug_detect;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] ticks;
    logic [15:0] address_shift;
    logic [15:0] command_shift;
    logic [3:0]  bit_position;
    logic [7:0]  last_key;
    logic [15:0] last_address;
  } state_t;

endpackage

### design/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC-style infrared frame decoder fed by tick and edge items.
// ----------------------------------------------------------------------------
// Input channel s_axis: one item per timer tick (tuser = 0) or receiver
// falling-edge interrupt (tuser = 1), with the sampled pin level in tdata.
// Output channel m_axis: exactly one result item per input item, carrying
// the event code in tuser and the last key, address, phase and tick count
// in tdata. The decoder state is updated as the item is accepted and the
// result lands in the output register, offered on m_axis in the cycle after.
// Throughput is one item per cycle: the output register is reloaded in the
// same cycle it is taken, so s_axis_tready stays high while m_axis flows.
// When the receiver stalls, one result is held and s_axis_tready drops
// until it is taken; nothing is dropped.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 leader_min,
// 1 leader_max, 2 one_min, 3 one_max, 4 idle_timeout, 5 unplug_detect);
// write only while the decoder is idle.
// Reset (rst, synchronous) restores default thresholds, clears the frame
// state and empties the output register.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] rx_level
  input  logic [0:0]                      s_axis_tuser,  // [0] opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // key_code, remote_id,
                                                         // decoder_phase, tick_count
  output logic [1:0]                      m_axis_tuser,  // [1:0] event_res
  input  logic                            cfg_we,
  input  logic [necir_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [necir_pkg::CfgDataW-1:0]  cfg_wdata
);

  necir_pkg::cfg_t   cfg;
  necir_pkg::state_t state;
  necir_pkg::state_t state_next;
  necir_pkg::event_t event_next;
  logic              accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min    <= necir_pkg::LEADER_MIN_RST;
      cfg.leader_max    <= necir_pkg::LEADER_MAX_RST;
      cfg.one_min       <= necir_pkg::ONE_MIN_RST;
      cfg.one_max       <= necir_pkg::ONE_MAX_RST;
      cfg.idle_timeout  <= necir_pkg::IDLE_TIMEOUT_RST;
      cfg.unplug_detect <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        necir_pkg::CFG_LEADER_MIN:    cfg.leader_min    <= cfg_wdata;
        necir_pkg::CFG_LEADER_MAX:    cfg.leader_max    <= cfg_wdata;
        necir_pkg::CFG_ONE_MIN:       cfg.one_min       <= cfg_wdata;
        necir_pkg::CFG_ONE_MAX:       cfg.one_max       <= cfg_wdata;
        necir_pkg::CFG_IDLE_TIMEOUT:  cfg.idle_timeout  <= cfg_wdata;
        necir_pkg::CFG_UNPLUG_DETECT: cfg.unplug_detect <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  necir_step u_step (
    .cfg        (cfg),
    .state      (state),
    .opcode     (s_axis_tuser[0]),
    .rx_level   (s_axis_tdata[0]),
    .state_next (state_next),
    .event_res  (event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= necir_pkg::PH_IDLE;
      state.ticks         <= 16'd0;
      state.address_shift <= 16'd0;
      state.command_shift <= 16'd0;
      state.bit_position  <= 4'd0;
      state.last_key      <= 8'd0;
      state.last_address  <= 16'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= event_next;
      m_axis_tdata <= {5'd0, state_next.ticks, state_next.phase,
                       state_next.last_address, state_next.last_key};
    end
  end

endmodule

### design/necir_step.sv
// ----------------------------------------------------------------------------
// necir_step
// Next-state and event logic for one tick or edge item.
// ----------------------------------------------------------------------------
module necir_step (
  input  necir_pkg::cfg_t   cfg,
  input  necir_pkg::state_t state,
  input  logic              opcode,
  input  logic              rx_level,
  output necir_pkg::state_t state_next,
  output necir_pkg::event_t event_res
);

  logic        low;
  logic [15:0] tick_inc;
  logic        timeout;
  logic        unplug_hold;
  logic        last_bit;
  logic        bit_one;
  logic        leader_ok;
  logic [15:0] bit_mask;
  logic [15:0] command_new;
  logic        command_ok;
  logic [3:0]  pos_next;
  necir_pkg::phase_t phase_next;

  assign low         = !rx_level;
  assign tick_inc    = (state.ticks != necir_pkg::TICK_SAT) ? state.ticks + 16'd1 : state.ticks;
  assign timeout     = (state.phase != necir_pkg::PH_IDLE) && (tick_inc > cfg.idle_timeout);
  assign unplug_hold = cfg.unplug_detect && low;
  assign last_bit    = (state.bit_position == 4'd0);
  assign bit_one     = (state.ticks > cfg.one_min) && (state.ticks < cfg.one_max);
  assign leader_ok   = (state.ticks > cfg.leader_min) && (state.ticks < cfg.leader_max);
  assign bit_mask    = {15'd0, bit_one} << state.bit_position;
  assign command_new = state.command_shift | bit_mask;
  assign command_ok  = ((command_new[15:8] ^ command_new[7:0]) == necir_pkg::CMD_CHECK);
  assign pos_next    = last_bit ? necir_pkg::BIT_TOP : state.bit_position - 4'd1;

  always_comb begin
    phase_next = state.phase;
    if (opcode == necir_pkg::OP_TICK) begin
      if (timeout) begin
        if (unplug_hold) begin
          if (state.phase == necir_pkg::PH_LEADER) phase_next = necir_pkg::PH_UNPLUGGED;
        end else begin
          phase_next = necir_pkg::PH_IDLE;
        end
      end
    end else begin
      unique case (state.phase)
        necir_pkg::PH_IDLE: begin
          if (low) phase_next = necir_pkg::PH_LEADER;
        end
        necir_pkg::PH_LEADER: begin
          if (low) phase_next = leader_ok ? necir_pkg::PH_ADDRESS : necir_pkg::PH_IDLE;
        end
        necir_pkg::PH_ADDRESS: begin
          if (low && last_bit) phase_next = necir_pkg::PH_COMMAND;
        end
        necir_pkg::PH_COMMAND: begin
          if (last_bit) phase_next = necir_pkg::PH_IDLE;
        end
        default: phase_next = state.phase;
      endcase
    end
  end

  always_comb begin
    state_next       = state;
    state_next.phase = phase_next;
    event_res        = necir_pkg::EV_NONE;
    if (opcode == necir_pkg::OP_TICK) begin
      state_next.ticks = tick_inc;
      if (timeout) begin
        if (unplug_hold) begin
          if (state.phase == necir_pkg::PH_LEADER) event_res = necir_pkg::EV_UNPLUG;
        end else begin
          state_next.ticks = 16'd0;
        end
      end
    end else begin
      unique case (state.phase)
        necir_pkg::PH_IDLE: begin
          if (low) begin
            state_next.ticks         = 16'd0;
            state_next.address_shift = 16'd0;
            state_next.command_shift = 16'd0;
            state_next.bit_position  = 4'd0;
          end
        end
        necir_pkg::PH_LEADER: begin
          if (low) begin
            state_next.ticks        = 16'd0;
            state_next.bit_position = necir_pkg::BIT_TOP;
          end
        end
        necir_pkg::PH_ADDRESS: begin
          if (low) begin
            state_next.ticks         = 16'd0;
            state_next.address_shift = state.address_shift | bit_mask;
            state_next.bit_position  = pos_next;
          end
        end
        necir_pkg::PH_COMMAND: begin
          state_next.ticks         = 16'd0;
          state_next.command_shift = command_new;
          state_next.bit_position  = pos_next;
          if (last_bit && command_ok) begin
            state_next.last_key     = command_new[15:8];
            state_next.last_address = state.address_shift;
            event_res               = necir_pkg::EV_KEY;
          end
        end
        default: state_next = state;
      endcase
    end
  end

endmodule

### design/necir_checker.sv
// ----------------------------------------------------------------------------
// necir_checker
// Port-level checks for the NEC infrared frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module necir_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        key_ev;
  logic        unplug_ev;
  logic [2:0]  phase;
  logic [15:0] ticks;

  assign key_ev    = m_axis_tvalid && (m_axis_tuser == necir_pkg::EV_KEY);
  assign unplug_ev = m_axis_tvalid && (m_axis_tuser == necir_pkg::EV_UNPLUG);
  assign phase     = m_axis_tdata[26:24];
  assign ticks     = m_axis_tdata[42:27];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held result changed under stall");

  a_key_frame_end: assert property (@(posedge clk) disable iff (rst)
    key_ev |-> (phase == necir_pkg::PH_IDLE) && (ticks == 16'd0))
    else $error("key event without frame end");

  a_unplug_phase: assert property (@(posedge clk) disable iff (rst)
    unplug_ev |-> (phase == necir_pkg::PH_UNPLUGGED) && (ticks != 16'd0))
    else $error("unplug event outside unplugged phase");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("unknown event code");

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/nec_ir_frame_decoder_test.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_test
// Self-checking bench for the NEC infrared frame decoder. Tick and edge items
// are streamed in with random gaps while the result side stalls at random.
// A behavioural copy of the decoder predicts every result item, which is
// compared field by field as it leaves the block. Directed checks cover idle
// behaviour, complement-valid keys and timeouts with and without unplug
// detection; random traffic then runs whole frames, broken frames and noise
// under several timing settings.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_test;

  typedef struct packed {
    necir_pkg::event_t ev;
    logic [7:0]        key;
    logic [15:0]       addr;
    necir_pkg::phase_t ph;
    logic [15:0]       ticks;
  } ir_result_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [0] rx_level
  logic [0:0]                     s_axis_tuser = '0;   // [0] opcode
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  logic [47:0]                    m_axis_tdata;        // [7:0] key_code, [23:8] remote_id,
                                                       // [26:24] decoder_phase,
                                                       // [42:27] tick_count
  logic [1:0]                     m_axis_tuser;        // [1:0] event_res
  logic                           cfg_we = 1'b0;
  logic [necir_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [necir_pkg::CfgDataW-1:0] cfg_wdata = '0;

  necir_pkg::cfg_t   timing = '{leader_min: necir_pkg::LEADER_MIN_RST,
                                leader_max: necir_pkg::LEADER_MAX_RST,
                                one_min: necir_pkg::ONE_MIN_RST,
                                one_max: necir_pkg::ONE_MAX_RST,
                                idle_timeout: necir_pkg::IDLE_TIMEOUT_RST,
                                unplug_detect: 1'b1};
  necir_pkg::phase_t dec_phase = necir_pkg::PH_IDLE;
  logic [15:0]       dec_ticks = '0;
  logic [15:0]       addr_bits = '0;
  logic [15:0]       cmd_bits = '0;
  logic [3:0]        bit_pos = '0;
  logic [7:0]        last_key_q = '0;
  logic [15:0]       last_addr_q = '0;

  ir_result_t  pending_reports[$];
  ir_result_t  head;
  int          errors = 0;
  int          items_sent = 0;
  int          keys_seen = 0;
  int          unplugs_seen = 0;
  int          settings_used = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  nec_ir_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("nec_ir_frame_decoder_test: FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic void decode_item(input necir_pkg::opcode_t op, input logic rx);
    ir_result_t  r;
    logic [15:0] t;
    logic        one;
    r.ev = necir_pkg::EV_NONE;
    t = dec_ticks;
    one = (t > timing.one_min) && (t < timing.one_max);
    if (op == necir_pkg::OP_TICK) begin
      if (dec_ticks != necir_pkg::TICK_SAT) dec_ticks++;
      if (dec_phase != necir_pkg::PH_IDLE && dec_ticks > timing.idle_timeout) begin
        if (timing.unplug_detect && !rx) begin
          if (dec_phase == necir_pkg::PH_LEADER) begin
            dec_phase = necir_pkg::PH_UNPLUGGED;
            r.ev = necir_pkg::EV_UNPLUG;
          end
        end else begin
          dec_ticks = '0;
          dec_phase = necir_pkg::PH_IDLE;
        end
      end
    end else begin
      case (dec_phase)
        necir_pkg::PH_IDLE: if (!rx) begin
          dec_ticks = '0;
          dec_phase = necir_pkg::PH_LEADER;
          addr_bits = '0;
          cmd_bits = '0;
          bit_pos = '0;
        end
        necir_pkg::PH_LEADER: if (!rx) begin
          dec_ticks = '0;
          dec_phase = (t > timing.leader_min && t < timing.leader_max) ?
                      necir_pkg::PH_ADDRESS : necir_pkg::PH_IDLE;
          bit_pos = necir_pkg::BIT_TOP;
        end
        necir_pkg::PH_ADDRESS: if (!rx) begin
          dec_ticks = '0;
          addr_bits[bit_pos] = addr_bits[bit_pos] | one;
          if (bit_pos == 0) dec_phase = necir_pkg::PH_COMMAND;
          bit_pos = bit_pos - 1'b1;
        end
        necir_pkg::PH_COMMAND: begin
          dec_ticks = '0;
          cmd_bits[bit_pos] = cmd_bits[bit_pos] | one;
          if (bit_pos == 0) begin
            dec_phase = necir_pkg::PH_IDLE;
            if ((cmd_bits[15:8] ^ cmd_bits[7:0]) == necir_pkg::CMD_CHECK) begin
              last_key_q = cmd_bits[15:8];
              last_addr_q = addr_bits;
              r.ev = necir_pkg::EV_KEY;
            end
          end
          bit_pos = bit_pos - 1'b1;
        end
        default: ;
      endcase
    end
    r.key = last_key_q;
    r.addr = last_addr_q;
    r.ph = dec_phase;
    r.ticks = dec_ticks;
    pending_reports.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic int pick_between(input int lo, input int hi);
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return lo;
  endfunction

  function automatic int pick_zero();
    if ($urandom_range(0, 1) == 0 || timing.one_max > 60000)
      return $urandom_range(0, timing.one_min);
    return timing.one_max + $urandom_range(0, 2);
  endfunction

  task automatic send_item(input necir_pkg::opcode_t op, input logic rx);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, rx};
    do @(posedge clk); while (!s_axis_tready);
    decode_item(op, rx);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_item(necir_pkg::OP_TICK, $urandom_range(0, 7) != 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic return_idle();
    while (dec_phase != necir_pkg::PH_IDLE) send_item(necir_pkg::OP_TICK, 1'b1);
  endtask

  task automatic set_timing(input logic [15:0] lmin, input logic [15:0] lmax,
                            input logic [15:0] omin, input logic [15:0] omax,
                            input logic [15:0] tmo, input logic unp);
    logic [necir_pkg::CfgIdxW-1:0]  regs [6];
    logic [necir_pkg::CfgDataW-1:0] vals [6];
    logic [14:0]                    stray;
    stray = 15'($urandom_range(0, 32767));
    regs = '{necir_pkg::CFG_LEADER_MIN, necir_pkg::CFG_LEADER_MAX, necir_pkg::CFG_ONE_MIN,
             necir_pkg::CFG_ONE_MAX, necir_pkg::CFG_IDLE_TIMEOUT,
             necir_pkg::CFG_UNPLUG_DETECT};
    vals = '{lmin, lmax, omin, omax, tmo, {stray, unp}};
    return_idle();
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    timing.leader_min = lmin;
    timing.leader_max = lmax;
    timing.one_min = omin;
    timing.one_max = omax;
    timing.idle_timeout = tmo;
    timing.unplug_detect = unp;
    settings_used++;
  endtask

  // leader, 16 address bits, 16 command bits; rough frames may break timing
  task automatic send_frame(input logic [15:0] addr, input logic [15:0] cmd, input bit rough);
    logic [31:0] bits;
    int          t;
    logic        lvl;
    bits = {addr, cmd};
    send_ticks($urandom_range(0, 2));
    send_item(necir_pkg::OP_EDGE, 1'b0);
    if (rough && $urandom_range(0, 3) == 0) t = $urandom_range(0, timing.leader_max + 3);
    else t = pick_between(int'(timing.leader_min), int'(timing.leader_max));
    send_ticks(t);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    for (int i = 31; i >= 0; i--) begin
      if (rough && $urandom_range(0, 24) == 0) t = timing.idle_timeout + $urandom_range(1, 3);
      else if (bits[i]) t = pick_between(int'(timing.one_min), int'(timing.one_max));
      else t = pick_zero();
      send_ticks(t);
      if (i >= 16 && $urandom_range(0, 9) == 0) send_item(necir_pkg::OP_EDGE, 1'b1);
      lvl = (i >= 16) ? 1'b0 : logic'($urandom_range(0, 1));
      send_item(necir_pkg::OP_EDGE, lvl);
    end
  endtask

  task automatic test_reset_idle();
    send_item(necir_pkg::OP_TICK, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_ticks(2);
    send_item(necir_pkg::OP_EDGE, 1'b0);
  endtask

  task automatic test_directed_keys();
    set_timing(16'd0, 16'd2, 16'd0, 16'd2, 16'd8, 1'b1);
    send_frame(16'hFFFF, 16'h00FF, 1'b0);
    send_frame(16'h0000, 16'hFF00, 1'b0);
  endtask

  task automatic test_timeouts();
    set_timing(16'd0, 16'd2, 16'd0, 16'd2, 16'd2, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    repeat (3) send_item(necir_pkg::OP_TICK, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b1);
    send_item(necir_pkg::OP_TICK, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b1);
    repeat (4) send_item(necir_pkg::OP_TICK, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    repeat (3) send_item(necir_pkg::OP_TICK, 1'b1);
    set_timing(16'd0, 16'd2, 16'd0, 16'd2, 16'd2, 1'b0);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    repeat (3) send_item(necir_pkg::OP_TICK, 1'b0);
    set_timing(16'd0, 16'd2, 16'd0, 16'd2, 16'd0, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
    send_item(necir_pkg::OP_EDGE, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b0);
    send_item(necir_pkg::OP_TICK, 1'b1);
  endtask

  task automatic test_random_traffic();
    int          start;
    int          cfg_mark;
    int          r;
    logic [15:0] lmin;
    logic [15:0] omin;
    logic [7:0]  k;
    start = items_sent;
    cfg_mark = -1000;
    while (items_sent - start < 1250) begin
      if (items_sent - cfg_mark > 280) begin
        lmin = 16'($urandom_range(0, 5));
        omin = 16'($urandom_range(0, 3));
        set_timing(lmin, 16'(lmin + $urandom_range(2, 6)), omin,
                   16'(omin + $urandom_range(2, 5)),
                   16'(($urandom_range(0, 4) == 0) ? $urandom_range(3, 8) :
                                                     $urandom_range(14, 40)),
                   1'($urandom_range(0, 1)));
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
        cfg_mark = items_sent;
      end
      r = $urandom_range(0, 9);
      k = 8'($urandom_range(0, 255));
      if (r < 7)
        send_frame(16'($urandom_range(0, 65535)),
                   (r < 5) ? {k, ~k} : 16'($urandom_range(0, 65535)), 1'b0);
      else if (r < 9)
        send_frame(16'($urandom_range(0, 65535)), {k, ~k}, 1'b1);
      else
        repeat ($urandom_range(1, 8))
          send_item(necir_pkg::opcode_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk) begin
    if (rst || !stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          m_axis_tready <= 1'b0;
          stall_left <= $urandom_range(0, 3);
        end
        4: begin
          m_axis_tready <= 1'b0;
          stall_left <= $urandom_range(6, 24);
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser == necir_pkg::EV_KEY) keys_seen++;
      else if (m_axis_tuser == necir_pkg::EV_UNPLUG) unplugs_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("result item with nothing expected");
      end else begin
        head = pending_reports.pop_front();
        if (m_axis_tuser !== head.ev)
          flag_mismatch($sformatf("event_res %0d, expected %0d", m_axis_tuser, head.ev));
        if (m_axis_tdata[7:0] !== head.key)
          flag_mismatch($sformatf("key_code %0h, expected %0h", m_axis_tdata[7:0], head.key));
        if (m_axis_tdata[23:8] !== head.addr)
          flag_mismatch($sformatf("remote_id %0h, expected %0h", m_axis_tdata[23:8], head.addr));
        if (m_axis_tdata[26:24] !== head.ph)
          flag_mismatch($sformatf("decoder_phase %0d, expected %0d", m_axis_tdata[26:24],
                                  head.ph));
        if (m_axis_tdata[42:27] !== head.ticks)
          flag_mismatch($sformatf("tick_count %0d, expected %0d", m_axis_tdata[42:27],
                                  head.ticks));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_idle();
    test_directed_keys();
    test_timeouts();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (pending_reports.size() != 0) flag_mismatch("expected results never arrived");
    $display("Sent %0d tick and edge items under %0d timing settings.",
             items_sent, settings_used);
    $display("Decoder reported %0d key events and %0d unplug events.", keys_seen, unplugs_seen);
    if (errors == 0) $display("nec_ir_frame_decoder_test: PASS");
    else $display("nec_ir_frame_decoder_test: FAIL");
    $finish;
  end

endmodule
